// ----- src/bss_pkg.sv -----
`timescale 1ns / 1ps
// Package for the brightness segment sequencer.
// Holds the field widths, request codes and the structs shared between the modules.
// No dependencies.

package bss_pkg;

    localparam int LEVEL_W = 8;
    localparam int DUR_W   = 24;
    localparam int IDX_W   = 4;
    localparam int LEN_W   = 5;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [IDX_W-1:0]   entry_index;
        logic [LEVEL_W-1:0] entry_level;
        logic [DUR_W-1:0]   entry_duration;
    } req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] current_level;
        logic [LEVEL_W-1:0] start_level;
        logic [LEVEL_W-1:0] end_level;
        logic [DUR_W-1:0]   time_left;
        logic [DUR_W-1:0]   segment_ticks;
        logic [IDX_W-1:0]   segment_index;
        logic               segment_loaded;
    } res_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   index;
        logic [LEVEL_W-1:0] level;
        logic [DUR_W-1:0]   duration;
    } wr_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_a;
        logic [DUR_W-1:0]   dur_a;
        logic [LEVEL_W-1:0] level_b;
    } rd_t;

endpackage

// ----- src/bss_req_if.sv -----
`timescale 1ns / 1ps
// Request channel of the brightness segment sequencer: valid, ready and one beat.
// Depends on bss_pkg for the field widths.

interface bss_req_if;

    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [bss_pkg::IDX_W-1:0]   entry_index;
    logic [bss_pkg::LEVEL_W-1:0] entry_level;
    logic [bss_pkg::DUR_W-1:0]   entry_duration;

    modport source (
        output valid,
        output req_type,
        output entry_index,
        output entry_level,
        output entry_duration,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  entry_index,
        input  entry_level,
        input  entry_duration,
        output ready
    );

endinterface

// ----- src/bss_res_if.sv -----
`timescale 1ns / 1ps
// Result channel of the brightness segment sequencer: valid, ready and one beat.
// Depends on bss_pkg for the field widths.

interface bss_res_if;

    logic                        valid;
    logic                        ready;
    logic [bss_pkg::LEVEL_W-1:0] current_level;
    logic [bss_pkg::LEVEL_W-1:0] start_level;
    logic [bss_pkg::LEVEL_W-1:0] end_level;
    logic [bss_pkg::DUR_W-1:0]   time_left;
    logic [bss_pkg::DUR_W-1:0]   segment_ticks;
    logic [bss_pkg::IDX_W-1:0]   segment_index;
    logic                        segment_loaded;

    modport source (
        output valid,
        output current_level,
        output start_level,
        output end_level,
        output time_left,
        output segment_ticks,
        output segment_index,
        output segment_loaded,
        input  ready
    );

    modport sink (
        input  valid,
        input  current_level,
        input  start_level,
        input  end_level,
        input  time_left,
        input  segment_ticks,
        input  segment_index,
        input  segment_loaded,
        output ready
    );

endinterface

// ----- src/brightness_segment_sequencer.sv -----
`timescale 1ns / 1ps
// Top level of the brightness segment sequencer: input register, core, result register.
// Depends on bss_pkg, bss_req_if, bss_res_if, bss_table and bss_core.
//
//   Channel   Direction  Handshake           Beat contents
//   req       in         req.valid/ready     req_type, entry_index, entry_level, entry_duration
//   rsp       out        rsp.valid/ready     levels, time left, segment ticks, index, loaded flag
//   cfg       in         cfg_wr_en           seq_length in cfg_wr_data
//
// Each request beat produces one result beat via the input register and the result register.
// A new beat is taken every cycle unless a result waits untaken; the next segment's table
// read is issued ahead so each tick finishes in one pass between input and result registers.
// Reset clears the segment state and the length; table entries hold nothing until loaded.
// When the result is not taken, the result register holds and the input register fills.

module brightness_segment_sequencer #(
    parameter int SEGMENTS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bss_req_if.sink                   req,
    bss_res_if.source                 rsp,
    input  logic                      cfg_wr_en,
    input  logic [bss_pkg::LEN_W-1:0] cfg_wr_data
);

    localparam int PTR_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

    logic             in_v_reg;
    bss_pkg::req_t    in_reg;
    logic             out_v_reg;
    bss_pkg::res_t    out_reg;
    logic             go;
    bss_pkg::res_t    res;
    bss_pkg::wr_t     wr;
    bss_pkg::rd_t     rd;
    logic [PTR_W-1:0] rd_addr_a;
    logic [PTR_W-1:0] rd_addr_b;

    assign go        = in_v_reg && (!out_v_reg || rsp.ready);
    assign req.ready = !in_v_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_v_reg <= req.valid;
            end
            if (go)
            begin
                out_v_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg.req_type       <= req.req_type;
            in_reg.entry_index    <= req.entry_index;
            in_reg.entry_level    <= req.entry_level;
            in_reg.entry_duration <= req.entry_duration;
        end
        if (go)
        begin
            out_reg <= res;
        end
    end

    bss_table #(
        .SEGMENTS (SEGMENTS)
    ) u_table (
        .clk       (clk),
        .wr        (wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd        (rd)
    );

    bss_core #(
        .SEGMENTS (SEGMENTS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .req         (in_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rd          (rd),
        .wr          (wr),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .res         (res)
    );

    assign rsp.valid          = out_v_reg;
    assign rsp.current_level  = out_reg.current_level;
    assign rsp.start_level    = out_reg.start_level;
    assign rsp.end_level      = out_reg.end_level;
    assign rsp.time_left      = out_reg.time_left;
    assign rsp.segment_ticks  = out_reg.segment_ticks;
    assign rsp.segment_index  = out_reg.segment_index;
    assign rsp.segment_loaded = out_reg.segment_loaded;

endmodule

// ----- src/bss_table.sv -----
`timescale 1ns / 1ps
// Segment table memory: one write port and two registered read ports.
// Depends on bss_pkg for the write and read structs.

module bss_table #(
    parameter int SEGMENTS = 16,
    localparam int PTR_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
) (
    input  logic                clk,
    input  bss_pkg::wr_t        wr,
    input  logic [PTR_W-1:0]    rd_addr_a,
    input  logic [PTR_W-1:0]    rd_addr_b,
    output bss_pkg::rd_t        rd
);

    localparam int AW = (PTR_W > bss_pkg::IDX_W) ? PTR_W : bss_pkg::IDX_W;

    logic [bss_pkg::LEVEL_W-1:0] level_mem [SEGMENTS];
    logic [bss_pkg::DUR_W-1:0]   dur_mem   [SEGMENTS];
    logic [AW-1:0]               wr_wide;
    logic [PTR_W-1:0]            wr_addr;
    bss_pkg::rd_t                rd_reg;

    assign wr_wide = AW'(wr.index);
    assign wr_addr = wr_wide[PTR_W-1:0];

    // A write in the same cycle is passed through so the read data track the table.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            level_mem[wr_addr] <= wr.level;
            dur_mem[wr_addr]   <= wr.duration;
        end
        rd_reg.level_a <= (wr.en && wr_addr == rd_addr_a) ? wr.level : level_mem[rd_addr_a];
        rd_reg.dur_a   <= (wr.en && wr_addr == rd_addr_a) ? wr.duration : dur_mem[rd_addr_a];
        rd_reg.level_b <= (wr.en && wr_addr == rd_addr_b) ? wr.level : level_mem[rd_addr_b];
    end

    assign rd = rd_reg;

endmodule

// ----- src/bss_core.sv -----
`timescale 1ns / 1ps
// Sequencer state and the combinational update for one request beat.
// Depends on bss_pkg; drives the addresses and write port of bss_table.

module bss_core #(
    parameter int SEGMENTS = 16,
    localparam int PTR_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  bss_pkg::req_t               req,
    input  logic                        cfg_wr_en,
    input  logic [bss_pkg::LEN_W-1:0]   cfg_wr_data,
    input  bss_pkg::rd_t                rd,
    output bss_pkg::wr_t                wr,
    output logic [PTR_W-1:0]            rd_addr_a,
    output logic [PTR_W-1:0]            rd_addr_b,
    output bss_pkg::res_t               res
);

    localparam int CW = (PTR_W + 1 > bss_pkg::LEN_W) ? PTR_W + 1 : bss_pkg::LEN_W;

    logic [bss_pkg::LEN_W-1:0]   len_reg;
    logic [bss_pkg::LEN_W-1:0]   len_next;
    logic [PTR_W-1:0]            ptr_reg;
    logic [PTR_W-1:0]            ptr_next;
    logic [bss_pkg::DUR_W-1:0]   remaining_reg;
    logic [bss_pkg::DUR_W-1:0]   remaining_next;
    logic [bss_pkg::DUR_W-1:0]   seg_dur_reg;
    logic [bss_pkg::DUR_W-1:0]   seg_dur_next;
    logic [bss_pkg::LEVEL_W-1:0] lvl_now_reg;
    logic [bss_pkg::LEVEL_W-1:0] lvl_now_next;
    logic [bss_pkg::LEVEL_W-1:0] lvl_start_reg;
    logic [bss_pkg::LEVEL_W-1:0] lvl_start_next;
    logic [bss_pkg::LEVEL_W-1:0] lvl_end_reg;
    logic [bss_pkg::LEVEL_W-1:0] lvl_end_next;
    logic                        loaded;
    logic [CW-1:0]               ptr_wide;

    function automatic logic [PTR_W-1:0] next_ptr(
        input logic [PTR_W-1:0]          p,
        input logic [bss_pkg::LEN_W-1:0] len
    );
        logic [CW-1:0] inc;
        inc = CW'(p) + CW'(1);
        if (inc < CW'(len) && inc < CW'(SEGMENTS))
        begin
            next_ptr = inc[PTR_W-1:0];
        end
        else
        begin
            next_ptr = '0;
        end
    endfunction

    always_comb
    begin
        ptr_next       = ptr_reg;
        remaining_next = remaining_reg;
        seg_dur_next   = seg_dur_reg;
        lvl_now_next   = lvl_now_reg;
        lvl_start_next = lvl_start_reg;
        lvl_end_next   = lvl_end_reg;
        loaded         = 1'b0;
        wr.en          = 1'b0;
        wr.index       = req.entry_index;
        wr.level       = req.entry_level;
        wr.duration    = req.entry_duration;
        if (go)
        begin
            if (req.req_type == bss_pkg::REQ_LOAD)
            begin
                wr.en = (CW'(req.entry_index) < CW'(SEGMENTS));
            end
            else
            begin
                priority if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - 1'b1;
                end
                else if (seg_dur_reg != '0)
                begin
                    seg_dur_next   = '0;
                    lvl_now_next   = lvl_end_reg;
                    lvl_start_next = '0;
                    lvl_end_next   = '0;
                end
                else if (len_reg != '0)
                begin
                    // The read ports already hold the following entry and the one after it.
                    ptr_next       = next_ptr(ptr_reg, len_reg);
                    seg_dur_next   = rd.dur_a;
                    remaining_next = rd.dur_a;
                    lvl_start_next = rd.level_a;
                    lvl_end_next   = rd.level_b;
                    lvl_now_next   = (rd.dur_a == '0) ? rd.level_b : rd.level_a;
                    loaded         = 1'b1;
                end
            end
        end
    end

    assign len_next  = cfg_wr_en ? cfg_wr_data : len_reg;
    assign rd_addr_a = next_ptr(ptr_next, len_next);
    assign rd_addr_b = next_ptr(rd_addr_a, len_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ptr_reg       <= '0;
            remaining_reg <= '0;
            seg_dur_reg   <= '0;
            lvl_now_reg   <= '0;
            lvl_start_reg <= '0;
            lvl_end_reg   <= '0;
        end
        else
        begin
            len_reg       <= len_next;
            ptr_reg       <= ptr_next;
            remaining_reg <= remaining_next;
            seg_dur_reg   <= seg_dur_next;
            lvl_now_reg   <= lvl_now_next;
            lvl_start_reg <= lvl_start_next;
            lvl_end_reg   <= lvl_end_next;
        end
    end

    assign ptr_wide = CW'(ptr_next);

    always_comb
    begin
        res.current_level  = lvl_now_next;
        res.start_level    = lvl_start_next;
        res.end_level      = lvl_end_next;
        res.time_left      = remaining_next;
        res.segment_ticks  = seg_dur_next;
        res.segment_index  = ptr_wide[bss_pkg::IDX_W-1:0];
        res.segment_loaded = loaded;
    end

endmodule
